// ----- rtl/transfer_boundary_splitter_assert.svh -----
// Assertion macros for the transfer boundary splitter.
`ifndef TRANSFER_BOUNDARY_SPLITTER_ASSERT_SVH
`define TRANSFER_BOUNDARY_SPLITTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define TBS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define TBS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tbs_pkg.sv -----
// Shared types and constants of the transfer boundary splitter.
`default_nettype none

package tbs_pkg;

  localparam int ADDR_W         = 48;
  localparam int CNT_W          = 30;
  localparam int LEN_OUT_W      = 26;
  localparam int FILL_W         = 8;
  localparam int KIND_W         = 3;
  localparam int BASE_W         = 48;
  localparam int USED_W         = 33;
  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 64;
  localparam int CHUNK_LOG2_DEF = 25;
  localparam int ADDR_BITS_DEF  = 48;
  localparam int MAX_BLOCKS     = 31;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_USED = 1'b1;

  localparam logic OP_FILL = 1'b0;
  localparam logic OP_COPY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SPLIT
  } tbs_state_t;

  typedef struct packed {
    logic load;
    logic classify;
    logic emit;
  } tbs_cmd_t;

  typedef struct packed {
    logic last;
  } tbs_stat_t;

endpackage

`default_nettype wire

// ----- rtl/transfer_boundary_splitter.sv -----
// Top level of the transfer boundary splitter.
//
//   Channel   Handshake                      Payload
//   request   start in, busy out             op, dst_addr, src_addr, byte_count,
//                                            fill_value, transfer_kind
//   chunk     chunk_valid out, one cycle     chunk_dst, chunk_src, chunk_len, out_op,
//                                            out_fill, out_kind, status, last
//   config    APB psel/penable/pwrite        paddr, pwdata, prdata, pready
//
// A request is taken when start is high and busy is low. A classify state checks it
// against the device window, then the split state emits one chunk per cycle, and busy
// stays high through both states.
// Each chunk appears on the outputs in the cycle after it is formed, for one cycle only.
// A rejected request, or one of zero bytes, gives a single transfer with last set.
// Reset is synchronous and clears the controller, the strobe and both registers.
// The receiver cannot stall; a new request may enter while the final chunk shows.
`default_nettype none
`include "transfer_boundary_splitter_assert.svh"

module transfer_boundary_splitter #(
  parameter int CHUNK_LOG2 = tbs_pkg::CHUNK_LOG2_DEF,
  parameter int ADDR_BITS  = tbs_pkg::ADDR_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           op,
  input  wire logic [tbs_pkg::ADDR_W-1:0]     dst_addr,
  input  wire logic [tbs_pkg::ADDR_W-1:0]     src_addr,
  input  wire logic [tbs_pkg::CNT_W-1:0]      byte_count,
  input  wire logic [tbs_pkg::FILL_W-1:0]     fill_value,
  input  wire logic [tbs_pkg::KIND_W-1:0]     transfer_kind,
  output logic                                chunk_valid,
  output logic      [tbs_pkg::ADDR_W-1:0]     chunk_dst,
  output logic      [tbs_pkg::ADDR_W-1:0]     chunk_src,
  output logic      [tbs_pkg::LEN_OUT_W-1:0]  chunk_len,
  output logic                                out_op,
  output logic      [tbs_pkg::FILL_W-1:0]     out_fill,
  output logic      [tbs_pkg::KIND_W-1:0]     out_kind,
  output logic                                status,
  output logic                                last,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tbs_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [tbs_pkg::PDATA_W-1:0]    pwdata,
  output logic      [tbs_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready
);
  import tbs_pkg::*;

  tbs_cmd_t          cmd;
  tbs_stat_t         stat;
  logic [BASE_W-1:0] region_base;
  logic [USED_W-1:0] region_used;

  tbs_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .region_base (region_base),
    .region_used (region_used)
  );

  tbs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  tbs_datapath #(
    .CHUNK_LOG2 (CHUNK_LOG2),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .region_base   (region_base),
    .region_used   (region_used),
    .op            (op),
    .dst_addr      (dst_addr),
    .src_addr      (src_addr),
    .byte_count    (byte_count),
    .fill_value    (fill_value),
    .transfer_kind (transfer_kind),
    .chunk_valid   (chunk_valid),
    .chunk_dst     (chunk_dst),
    .chunk_src     (chunk_src),
    .chunk_len     (chunk_len),
    .out_op        (out_op),
    .out_fill      (out_fill),
    .out_kind      (out_kind),
    .status        (status),
    .last          (last)
  );

  // An accepted request keeps the block busy while it is classified.
  `TBS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  // A rejection is always a single final transfer with no length.
  `TBS_ASSERT_IMP(a_reject_last, chunk_valid && status, last && (chunk_len == '0),
                  "rejected request not a single empty final chunk")
  // After the final chunk the controller is idle, so no chunk follows at once.
  `TBS_ASSERT_NXT(a_last_gap, chunk_valid && last, !chunk_valid,
                  "chunk emitted directly after the final chunk")
  // While idle nothing is being split, so no chunk can be formed.
  `TBS_ASSERT_NXT(a_idle_quiet, !busy && !$past(busy), !chunk_valid,
                  "chunk emitted while the block was idle")

endmodule

`default_nettype wire

// ----- rtl/tbs_regs.sv -----
// APB configuration registers holding the device window.
`default_nettype none

module tbs_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tbs_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [tbs_pkg::PDATA_W-1:0]   pwdata,
  output logic      [tbs_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output logic      [tbs_pkg::BASE_W-1:0]    region_base,
  output logic      [tbs_pkg::USED_W-1:0]    region_used
);
  import tbs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      region_used <= '0;
    end else if (wr_en) begin
      unique case (paddr[3])
        REG_BASE: region_base <= pwdata[BASE_W-1:0];
        REG_USED: region_used <= pwdata[USED_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_BASE: prdata = PDATA_W'(region_base);
      REG_USED: prdata = PDATA_W'(region_used);
      default:  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tbs_ctrl.sv -----
// Controller state machine sequencing load, classification and chunk emission.
`default_nettype none

module tbs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  output tbs_pkg::tbs_cmd_t        cmd,
  input  wire tbs_pkg::tbs_stat_t  stat
);
  import tbs_pkg::*;

  tbs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (start) state_next = ST_CLASSIFY;
      ST_CLASSIFY: state_next = ST_SPLIT;
      ST_SPLIT:    if (stat.last) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CLASSIFY: cmd.classify = 1'b1;
      ST_SPLIT:    cmd.emit     = 1'b1;
      default:     busy         = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tbs_datapath.sv -----
// Datapath: request registers, window test, chunk length and result registers.
`default_nettype none

module tbs_datapath #(
  parameter int CHUNK_LOG2 = tbs_pkg::CHUNK_LOG2_DEF,
  parameter int ADDR_BITS  = tbs_pkg::ADDR_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire tbs_pkg::tbs_cmd_t              cmd,
  output tbs_pkg::tbs_stat_t                  stat,
  input  wire logic [tbs_pkg::BASE_W-1:0]     region_base,
  input  wire logic [tbs_pkg::USED_W-1:0]     region_used,
  input  wire logic                           op,
  input  wire logic [tbs_pkg::ADDR_W-1:0]     dst_addr,
  input  wire logic [tbs_pkg::ADDR_W-1:0]     src_addr,
  input  wire logic [tbs_pkg::CNT_W-1:0]      byte_count,
  input  wire logic [tbs_pkg::FILL_W-1:0]     fill_value,
  input  wire logic [tbs_pkg::KIND_W-1:0]     transfer_kind,
  output logic                                chunk_valid,
  output logic      [tbs_pkg::ADDR_W-1:0]     chunk_dst,
  output logic      [tbs_pkg::ADDR_W-1:0]     chunk_src,
  output logic      [tbs_pkg::LEN_OUT_W-1:0]  chunk_len,
  output logic                                out_op,
  output logic      [tbs_pkg::FILL_W-1:0]     out_fill,
  output logic      [tbs_pkg::KIND_W-1:0]     out_kind,
  output logic                                status,
  output logic                                last
);
  import tbs_pkg::*;

  localparam int AW  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int LW  = CHUNK_LOG2 + 1;
  localparam int CW  = (LW > CNT_W) ? LW : CNT_W;
  localparam int EW  = BASE_W + 1;
  localparam logic [63:0]   MaxBytes   = 64'(MAX_BLOCKS) << CHUNK_LOG2;
  localparam logic [LW-1:0] BlockBytes = {1'b1, {CHUNK_LOG2{1'b0}}};

  // Request held while it is being split.
  logic              op_q;
  logic [AW-1:0]     dst;
  logic [AW-1:0]     src;
  logic [CNT_W-1:0]  rem;
  logic [FILL_W-1:0] fill_q;
  logic [KIND_W-1:0] kind_q;
  logic              reject;
  logic              split_d;
  logic              split_s;

  logic [EW-1:0]     region_end;
  logic              rem_small;
  logic [LW-1:0]     len_base;
  logic [LW-1:0]     room_d;
  logic [LW-1:0]     room_s;
  logic [LW-1:0]     len_d;
  logic [LW-1:0]     len;
  logic              last_chunk;

  function automatic logic in_win(input logic [AW-1:0] a, input logic [BASE_W-1:0] base,
                                  input logic [EW-1:0] lim);
    logic [EW-1:0] ax;
    ax     = EW'(a);
    in_win = (ax >= EW'(base)) && (ax < lim);
  endfunction

  assign region_end = EW'(region_base) + EW'(region_used);

  // A chunk is at most one block, and stops at each boundary that applies.
  assign rem_small  = (rem >> CHUNK_LOG2) == '0;
  assign len_base   = rem_small ? LW'(rem) : BlockBytes;
  assign room_d     = BlockBytes - {1'b0, dst[CHUNK_LOG2-1:0]};
  assign room_s     = BlockBytes - {1'b0, src[CHUNK_LOG2-1:0]};
  assign len_d      = (split_d && (room_d < len_base)) ? room_d : len_base;
  assign len        = (split_s && (room_s < len_d)) ? room_s : len_d;
  assign last_chunk = reject || (CW'(len) == CW'(rem));
  assign stat.last  = last_chunk;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      dst    <= dst_addr[AW-1:0];
      src    <= (op == OP_COPY) ? src_addr[AW-1:0] : '0;
      rem    <= byte_count;
      fill_q <= fill_value;
      kind_q <= transfer_kind;
      reject <= 64'(byte_count) > MaxBytes;
    end else if (cmd.classify) begin
      split_d <= (op_q == OP_FILL) || in_win(dst, region_base, region_end);
      split_s <= (op_q == OP_COPY) && in_win(src, region_base, region_end);
    end else if (cmd.emit) begin
      rem <= rem - CNT_W'(len);
      dst <= dst + AW'(len);
      if (op_q == OP_COPY) begin
        src <= src + AW'(len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_valid <= 1'b0;
    end else begin
      chunk_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_op   <= op_q;
      out_fill <= fill_q;
      out_kind <= kind_q;
      status   <= reject;
      last     <= last_chunk;
      if (reject) begin
        chunk_dst <= '0;
        chunk_src <= '0;
        chunk_len <= '0;
      end else begin
        chunk_dst <= ADDR_W'(dst);
        chunk_src <= ADDR_W'(src);
        chunk_len <= LEN_OUT_W'(len);
      end
    end
  end

endmodule

`default_nettype wire

// ----- verif/transfer_boundary_splitter_checker.sv -----
// Checker for the transfer boundary splitter: predicts every chunk of a request and compares.
module transfer_boundary_splitter_checker #(
  parameter int CHUNK_LOG2 = tbs_pkg::CHUNK_LOG2_DEF,
  parameter int ADDR_BITS  = tbs_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           op,
  input  logic [tbs_pkg::ADDR_W-1:0]     dst_addr,
  input  logic [tbs_pkg::ADDR_W-1:0]     src_addr,
  input  logic [tbs_pkg::CNT_W-1:0]      byte_count,
  input  logic [tbs_pkg::FILL_W-1:0]     fill_value,
  input  logic [tbs_pkg::KIND_W-1:0]     transfer_kind,
  input  logic                           chunk_valid,
  input  logic [tbs_pkg::ADDR_W-1:0]     chunk_dst,
  input  logic [tbs_pkg::ADDR_W-1:0]     chunk_src,
  input  logic [tbs_pkg::LEN_OUT_W-1:0]  chunk_len,
  input  logic                           out_op,
  input  logic [tbs_pkg::FILL_W-1:0]     out_fill,
  input  logic [tbs_pkg::KIND_W-1:0]     out_kind,
  input  logic                           status,
  input  logic                           last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [tbs_pkg::PADDR_W-1:0]    paddr,
  input  logic [tbs_pkg::PDATA_W-1:0]    pwdata,
  output int                             fail_count,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import tbs_pkg::*;

  localparam longint unsigned BLOCK      = 64'd1 << CHUNK_LOG2;
  localparam longint unsigned MAX_BYTES  = MAX_BLOCKS * BLOCK;
  localparam longint unsigned WRAP_MASK  = {64{1'b1}} >> (64 - ADDR_BITS);
  localparam int              MAX_CHUNKS = 64;

  // The registers are 64 bits wide on the bus, so they sit at 8-byte steps.
  localparam logic [PADDR_W-1:0] BASE_ADDR = {REG_BASE, 3'b000};
  localparam logic [PADDR_W-1:0] USED_ADDR = {REG_USED, 3'b000};

  typedef struct {
    logic [ADDR_W-1:0]    dst;
    logic [ADDR_W-1:0]    src;
    logic [LEN_OUT_W-1:0] len;
    logic                 op;
    logic [FILL_W-1:0]    fill;
    logic [KIND_W-1:0]    kind;
    logic                 status;
    logic                 last;
  } chunk_t;

  chunk_t          expected_chunks[$];
  chunk_t          oldest;
  longint unsigned window_base = 0;
  longint unsigned window_used = 0;

  initial fail_count = 0;
  initial outstanding = 0;

  function automatic bit in_window(longint unsigned a);
    return a >= window_base && a < window_base + window_used;
  endfunction

  function automatic longint unsigned room_to_boundary(longint unsigned a);
    return BLOCK - (a & (BLOCK - 1));
  endfunction

  function automatic void split_request(logic rop, logic [ADDR_W-1:0] rdst,
                                        logic [ADDR_W-1:0] rsrc, logic [CNT_W-1:0] rcnt,
                                        logic [FILL_W-1:0] rfill, logic [KIND_W-1:0] rkind);
    longint unsigned d;
    longint unsigned s;
    longint unsigned remaining;
    longint unsigned len;
    bit split_dst;
    bit split_src;
    int n;
    chunk_t c;
    d = rdst & WRAP_MASK;
    s = rsrc & WRAP_MASK;
    remaining = rcnt;
    c.op = rop;
    c.fill = rfill;
    c.kind = rkind;
    c.status = 1'b0;
    c.last = 1'b1;
    c.dst = '0;
    c.src = '0;
    c.len = '0;
    // An over-long request is refused with one zeroed status transfer.
    if (remaining > MAX_BYTES) begin
      c.status = 1'b1;
      expected_chunks.push_back(c);
      return;
    end
    if (rop == OP_FILL) begin
      s = 0;
      split_dst = 1'b1;
      split_src = 1'b0;
    end else begin
      split_dst = in_window(d);
      split_src = in_window(s);
    end
    if (remaining == 0) begin
      c.dst = d[ADDR_W-1:0];
      c.src = s[ADDR_W-1:0];
      expected_chunks.push_back(c);
      return;
    end
    n = 0;
    while (remaining > 0 && n < MAX_CHUNKS) begin
      len = remaining < BLOCK ? remaining : BLOCK;
      if (split_dst && room_to_boundary(d) < len) len = room_to_boundary(d);
      if (split_src && room_to_boundary(s) < len) len = room_to_boundary(s);
      remaining -= len;
      c.dst = d[ADDR_W-1:0];
      c.src = s[ADDR_W-1:0];
      c.len = len[LEN_OUT_W-1:0];
      c.last = (remaining == 0);
      expected_chunks.push_back(c);
      n++;
      d = (d + len) & WRAP_MASK;
      if (rop == OP_COPY) s = (s + len) & WRAP_MASK;
    end
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_chunks.delete();
      window_base = 0;
      window_used = 0;
    end else begin
      if (chunk_valid) begin
        if (expected_chunks.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected chunk transfer, expected none, actual dst 0x%0h len 0x%0h",
                   $time, chunk_dst, chunk_len);
        end else begin
          oldest = expected_chunks.pop_front();
          check_field("chunk_dst", oldest.dst, chunk_dst);
          check_field("chunk_src", oldest.src, chunk_src);
          check_field("chunk_len", oldest.len, chunk_len);
          check_field("out_op", oldest.op, out_op);
          check_field("out_fill", oldest.fill, out_fill);
          check_field("out_kind", oldest.kind, out_kind);
          check_field("status", oldest.status, status);
          check_field("last", oldest.last, last);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == BASE_ADDR) window_base = pwdata[BASE_W-1:0];
        else if (paddr == USED_ADDR) window_used = pwdata[USED_W-1:0];
      end
      if (start && !busy) begin
        split_request(op, dst_addr, src_addr, byte_count, fill_value, transfer_kind);
      end
    end
    outstanding <= expected_chunks.size();
  end

endmodule

// ----- verif/tb_transfer_boundary_splitter.sv -----
// Testbench top for the transfer boundary splitter: clock, reset, stimulus and verdict.
module tb_transfer_boundary_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  import tbs_pkg::*;

  localparam longint unsigned BLOCK       = 64'd1 << CHUNK_LOG2_DEF;
  localparam longint unsigned MAX_BYTES   = MAX_BLOCKS * BLOCK;
  localparam logic [ADDR_W-1:0] ADDR_TOP  = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [USED_W-1:0] USED_MAX  = '1;
  localparam logic [PADDR_W-1:0] BASE_ADDR = {REG_BASE, 3'b000};
  localparam logic [PADDR_W-1:0] USED_ADDR = {REG_USED, 3'b000};
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 op = OP_FILL;
  logic [ADDR_W-1:0]    dst_addr = '0;
  logic [ADDR_W-1:0]    src_addr = '0;
  logic [CNT_W-1:0]     byte_count = '0;
  logic [FILL_W-1:0]    fill_value = '0;
  logic [KIND_W-1:0]    transfer_kind = '0;
  logic                 chunk_valid;
  logic [ADDR_W-1:0]    chunk_dst;
  logic [ADDR_W-1:0]    chunk_src;
  logic [LEN_OUT_W-1:0] chunk_len;
  logic                 out_op;
  logic [FILL_W-1:0]    out_fill;
  logic [KIND_W-1:0]    out_kind;
  logic                 status;
  logic                 last;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  int                   fail_count;
  int                   outstanding;

  // Stimulus-side copy of the window, used only to aim addresses into it and at its edges.
  longint unsigned win_base = 0;
  longint unsigned win_used = 0;
  int unsigned     idle_pct = 0;

  transfer_boundary_splitter uut (.*);

  transfer_boundary_splitter_checker checker_i (.*);

  always #10 clk = ~clk;

  initial begin
    #10ms;
    $display("FAIL transfer_boundary_splitter");
    $finish;
  end

  task automatic send_request(logic o, logic [ADDR_W-1:0] d, logic [ADDR_W-1:0] s,
                              logic [CNT_W-1:0] n, logic [FILL_W-1:0] f,
                              logic [KIND_W-1:0] k);
    op <= o;
    dst_addr <= d;
    src_addr <= s;
    byte_count <= n;
    fill_value <= f;
    transfer_kind <= k;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Lets every outstanding chunk arrive so that the block is idle.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(longint unsigned base, longint unsigned used);
    settle();
    write_reg(BASE_ADDR, base);
    write_reg(USED_ADDR, used);
    win_base = base & ADDR_TOP;
    win_used = used & USED_MAX;
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [63:0] r;
    logic [63:0] a;
    r = {$urandom, $urandom};
    case ($urandom_range(4))
      0, 1: a = r;
      2: a = (win_used != 0) ? win_base + r % win_used : r;
      3: begin
        case ($urandom_range(3))
          0: a = win_base;
          1: a = win_base - 1;
          2: a = win_base + win_used;
          default: a = win_base + win_used - 1;
        endcase
      end
      default: a = win_base + r[35:0];
    endcase
    // Often park the address just short of a block boundary.
    if ($urandom_range(2) == 0) a[CHUNK_LOG2_DEF-1:0] = BLOCK - $urandom_range(64, 1);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 3) return '0;
    if (k < 7) return $urandom_range(CNT_MAX, MAX_BYTES + 1);
    if (k < 10) return $urandom_range(MAX_BYTES, 1);
    if (k < 35) return $urandom_range(3 * BLOCK, 1);
    return $urandom_range(4096, 1);
  endfunction

  task automatic random_request();
    logic [ADDR_W-1:0] d;
    logic [ADDR_W-1:0] s;
    d = pick_addr();
    s = pick_addr();
    send_request(logic'($urandom_range(1)), d, s, pick_count(), FILL_W'($urandom),
                 KIND_W'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Window empty after reset: every copy goes through unsplit.
    send_request(OP_FILL, '0, '0, 1, 8'h00, 3'd0);
    send_request(OP_FILL, BLOCK - 3, ADDR_TOP, 2 * BLOCK + 10, 8'hFF, 3'd1);
    send_request(OP_FILL, 12345, '0, MAX_BYTES, 8'hA5, 3'd2);
    send_request(OP_COPY, '0, '0, MAX_BYTES + 1, 8'h5A, 3'd3);
    send_request(OP_FILL, ADDR_TOP, ADDR_TOP, CNT_MAX, 8'hFF, 3'd7);
    send_request(OP_FILL, ADDR_TOP, 48'h1234, 0, 8'h11, 3'd4);
    send_request(OP_COPY, 5, ADDR_TOP, 0, 8'h22, 3'd5);
    send_request(OP_COPY, 100, BLOCK - 1, 3 * BLOCK + 5, 8'h3C, 3'd4);
    send_request(OP_FILL, ADDR_TOP - 9, '0, 100, 8'h01, 3'd6);
    send_request(OP_COPY, ADDR_TOP - 4, ADDR_TOP, BLOCK + 20, 8'h80, 3'd6);
    send_request(OP_COPY, 48'h7, 48'h9, MAX_BYTES, 8'h7F, 3'd0);

    set_window(3 * BLOCK + 256, 2 * BLOCK);
    send_request(OP_COPY, win_base, 16, BLOCK, 8'h10, 3'd1);
    send_request(OP_COPY, ADDR_TOP - 4096, win_base + BLOCK - 2, 3 * BLOCK, 8'h20, 3'd2);
    send_request(OP_COPY, win_base + 7, win_base + BLOCK + 128, 2 * BLOCK + 4096, 8'h30, 3'd3);
    send_request(OP_COPY, win_base - 1, win_base + win_used, 5, 8'h40, 3'd4);
    send_request(OP_COPY, win_base + win_used - 1, win_base, MAX_BYTES, 8'h50, 3'd5);
    send_request(OP_FILL, win_base + 1, win_base, 2 * BLOCK, 8'h60, 3'd7);

    set_window(ADDR_TOP, USED_MAX);
    send_request(OP_COPY, ADDR_TOP, ADDR_TOP, 2 * BLOCK, 8'h70, 3'd2);
    send_request(OP_COPY, ADDR_TOP - 1, '0, 40, 8'h90, 3'd1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          set_window({$urandom, $urandom}, $urandom);
          idle_pct = 0;
        end
        1: begin
          set_window(0, 64'd1 << 32);
          idle_pct = 62;
        end
        2: begin
          set_window(ADDR_TOP, USED_MAX);
          idle_pct = 35;
        end
        3: begin
          set_window({$urandom, $urandom}, 0);
          idle_pct = 62;
        end
        4: begin
          set_window({$urandom, $urandom}, $urandom_range(4 * BLOCK, 1));
          idle_pct = 0;
        end
        default: begin
          set_window({$urandom, $urandom} & ~(BLOCK - 1), {$urandom_range(1), $urandom});
          idle_pct = 35;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_request();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS transfer_boundary_splitter");
    end else begin
      $display("FAIL transfer_boundary_splitter");
    end
    $finish;
  end

endmodule
